FILE: rtl/core/mgcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mgcd_pkg
// Shared widths and types of the multi-operand GCD block.
// ----------------------------------------------------------------------------
package mgcd_pkg;

  // Operand width and the width of the common power-of-two count
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned SHIFT_W    = $clog2(DATA_WIDTH);

  // Request to the GCD unit: start strobe and the two magnitudes
  typedef struct packed {
    logic                  start;
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
  } req_t;

  // Response of the GCD unit: one-cycle done strobe and the divisor
  typedef struct packed {
    logic                  done;
    logic [DATA_WIDTH-1:0] result;
  } rsp_t;

endpackage
`default_nettype wire

FILE: rtl/core/mgcd_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mgcd_in_if
// Operand channel: one signed value per beat, last closes the set.
// ----------------------------------------------------------------------------
interface mgcd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mgcd_pkg::DATA_WIDTH-1:0] value;
  logic                                 last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/mgcd_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mgcd_out_if
// Result channel: one unsigned divisor per closed set.
// ----------------------------------------------------------------------------
interface mgcd_out_if;
  logic                           valid;
  logic                           ready;
  logic [mgcd_pkg::DATA_WIDTH-1:0] divisor;

  modport source (output valid, output divisor, input ready);
  modport sink   (input valid, input divisor, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/mgcd_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mgcd_unit
// Iterative binary GCD of two unsigned magnitudes. One shift or one
// compare-and-subtract per cycle; the common power of two is restored at
// the end with a single shift.
// ----------------------------------------------------------------------------
module mgcd_unit (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  mgcd_pkg::req_t   req_i,
  output mgcd_pkg::rsp_t   rsp_o
);

  typedef enum logic [2:0] {
    U_IDLE,
    U_CHECK,
    U_TWOS,
    U_REDUCE,
    U_SCALE
  } ust_e;

  ust_e                            st_q, st_d;
  logic [mgcd_pkg::DATA_WIDTH-1:0] a_q, a_d;
  logic [mgcd_pkg::DATA_WIDTH-1:0] b_q, b_d;
  logic [mgcd_pkg::SHIFT_W-1:0]    k_q, k_d;
  logic [mgcd_pkg::DATA_WIDTH-1:0] res_q, res_d;
  logic                            done_q, done_d;

  logic                            a_gt_b;
  logic [mgcd_pkg::DATA_WIDTH-1:0] big, sml, diff;

  // Shared compare and subtract: larger minus smaller
  assign a_gt_b = (a_q > b_q);
  assign big    = a_gt_b ? a_q : b_q;
  assign sml    = a_gt_b ? b_q : a_q;
  assign diff   = big - sml;

  // Sequence the reduction steps
  always_comb begin
    st_d   = st_q;
    a_d    = a_q;
    b_d    = b_q;
    k_d    = k_q;
    res_d  = res_q;
    done_d = 1'b0;
    unique case (st_q)
      U_IDLE: begin
        if (req_i.start) begin
          a_d  = req_i.a;
          b_d  = req_i.b;
          k_d  = '0;
          st_d = U_CHECK;
        end
      end
      U_CHECK: begin
        priority if (a_q == '0) begin
          res_d  = b_q;
          done_d = 1'b1;
          st_d   = U_IDLE;
        end else if (b_q == '0) begin
          res_d  = a_q;
          done_d = 1'b1;
          st_d   = U_IDLE;
        end else begin
          st_d = U_TWOS;
        end
      end
      U_TWOS: begin
        // strip the common factors of two, counting them
        if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + mgcd_pkg::SHIFT_W'(1);
        end else begin
          st_d = U_REDUCE;
        end
      end
      U_REDUCE: begin
        priority if (a_q == b_q) begin
          st_d = U_SCALE;
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (a_gt_b) begin
          a_d = diff;
        end else begin
          b_d = diff;
        end
      end
      U_SCALE: begin
        res_d  = a_q << k_q;
        done_d = 1'b1;
        st_d   = U_IDLE;
      end
      default: begin
        st_d = U_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= U_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  // Advance the operand, count and result registers
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    k_q   <= k_d;
    res_q <= res_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

  // Both operands stay nonzero once reduction starts
  a_reduce_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == U_REDUCE) |-> (a_q != '0 && b_q != '0))
    else $error("mgcd_unit: zero operand during reduction");

  // Odd-odd subtraction always leaves an even nonzero difference
  a_diff_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == U_REDUCE && a_q != b_q && a_q[0] && b_q[0]) |-> (!diff[0] && diff != '0))
    else $error("mgcd_unit: odd or zero difference");

  // A start is only taken while idle
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> (st_q == U_IDLE))
    else $error("mgcd_unit: start while busy");

endmodule
`default_nettype wire

FILE: rtl/core/multi_operand_gcd.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_operand_gcd
// Greatest common divisor of a list of signed operands. Each magnitude is
// folded into a running divisor; the operand marked last emits the divisor.
// ----------------------------------------------------------------------------
//  channel  dir  payload               beat rule
//  in_i     in   value[31:0] s, last   valid & ready
//  out_o    out  divisor[31:0] u       valid & ready, one beat per set
//
//  Folding: the first operand of a set, and every operand after the running
//  divisor has reached 1, finishes at once. Other operands run the binary
//  GCD unit, which ends early when either operand is zero and otherwise
//  halves or subtracts until the operands match, in the single
//  shift/subtract loop; input is not ready while the unit runs.
//  Reset: asynchronous, active low; no clearing pass.
//  Stalls: a held result blocks input only when the next closing operand
//  finishes before the result is taken.
// ----------------------------------------------------------------------------
module multi_operand_gcd (
  input  wire               clk_i,
  input  wire               rst_ni,
  mgcd_in_if.sink           in_i,
  mgcd_out_if.source        out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_EMIT
  } st_e;

  st_e                             st_q, st_d;
  logic [mgcd_pkg::DATA_WIDTH-1:0] rd_q, rd_d;
  logic                            set_start_q, set_start_d;
  logic                            last_q, last_d;
  logic                            out_valid_q, out_valid_d;
  logic [mgcd_pkg::DATA_WIDTH-1:0] out_div_q, out_div_d;

  mgcd_pkg::req_t                  req;
  mgcd_pkg::rsp_t                  rsp;

  logic                            acc;
  logic                            slot_free;
  logic [mgcd_pkg::DATA_WIDTH-1:0] mag;
  logic                            fin_en;
  logic                            fin_last;
  logic [mgcd_pkg::DATA_WIDTH-1:0] fin_val;

  // Magnitude held unsigned, so the most negative value does not overflow
  assign mag = in_i.value[mgcd_pkg::DATA_WIDTH-1]
             ? (~in_i.value + mgcd_pkg::DATA_WIDTH'(1))
             : in_i.value;

  assign in_i.ready = (st_q == S_IDLE);
  assign acc        = in_i.valid && in_i.ready;
  assign slot_free  = !out_valid_q || out_o.ready;

  // Operands that need no reduction finish at once; others when the unit is done
  assign fin_en   = (acc && (set_start_q || rd_q == mgcd_pkg::DATA_WIDTH'(1)))
                  || (st_q == S_RUN && rsp.done);
  assign fin_val  = (st_q == S_RUN) ? rsp.result : (set_start_q ? mag : rd_q);
  assign fin_last = (st_q == S_RUN) ? last_q : in_i.last;

  // Fold operands and route results to the output register
  always_comb begin
    st_d        = st_q;
    rd_d        = rd_q;
    set_start_d = set_start_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_div_d   = out_div_q;
    req.start   = 1'b0;
    req.a       = mag;
    req.b       = rd_q;

    unique case (st_q)
      S_IDLE: begin
        if (acc && !fin_en) begin
          req.start = 1'b1;
          last_d    = in_i.last;
          st_d      = S_RUN;
        end
      end
      S_RUN: begin
        // wait for the unit
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_div_d   = rd_q;
          rd_d        = '0;
          set_start_d = 1'b1;
          st_d        = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase

    if (fin_en) begin
      if (!fin_last) begin
        rd_d        = fin_val;
        set_start_d = 1'b0;
        st_d        = S_IDLE;
      end else if (slot_free) begin
        out_valid_d = 1'b1;
        out_div_d   = fin_val;
        rd_d        = '0;
        set_start_d = 1'b1;
        st_d        = S_IDLE;
      end else begin
        rd_d = fin_val;
        st_d = S_EMIT;
      end
    end
  end

  // Hold state and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      rd_q        <= '0;
      set_start_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      rd_q        <= rd_d;
      set_start_q <= set_start_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Advance the last flag and the output divisor
  always_ff @(posedge clk_i) begin
    last_q    <= last_d;
    out_div_q <= out_div_d;
  end

  mgcd_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign out_o.valid   = out_valid_q;
  assign out_o.divisor = out_div_q;

  // The unit is never started for a trivial fold
  a_start_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.start |-> (!set_start_q && rd_q != mgcd_pkg::DATA_WIDTH'(1)))
    else $error("multi_operand_gcd: unit started without need");

  // Unit results arrive only while waiting for them
  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (st_q == S_RUN))
    else $error("multi_operand_gcd: stray unit result");

  // A pending result is loaded as soon as the output slot frees up
  a_emit_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_EMIT && slot_free) |=> (out_valid_q && set_start_q))
    else $error("multi_operand_gcd: pending result not emitted");

  // A running divisor of 1 stays 1 until the set closes
  a_one_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE && !set_start_q && rd_q == mgcd_pkg::DATA_WIDTH'(1) && acc && !in_i.last)
    |=> (rd_q == mgcd_pkg::DATA_WIDTH'(1)))
    else $error("multi_operand_gcd: divisor left 1");

endmodule
`default_nettype wire

FILE: tb/multi_operand_gcd_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_operand_gcd_test
// Self-checking bench for the multi-operand GCD block. Operand sets are fed
// through the input channel with random gaps, each beat is folded into a
// local running divisor, and every divisor beat on the output channel is
// compared with the oldest predicted divisor. Random back-pressure, a long
// receiver hold and a stretch without idling exercise the handshakes.
// ----------------------------------------------------------------------------
module multi_operand_gcd_test;

  localparam int unsigned DW           = mgcd_pkg::DATA_WIDTH;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 2 * DW + 40;
  localparam int unsigned RANDOM_ITEMS = 900;

  logic clk;
  logic rst_n;

  mgcd_in_if  operand_ch ();
  mgcd_out_if gcd_ch ();

  multi_operand_gcd dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (operand_ch),
    .out_o  (gcd_ch)
  );

  // Predicted state of the block
  logic [DW-1:0] running_gcd;
  logic          set_open;
  logic [DW-1:0] divisor_q[$];

  int unsigned errors;
  int unsigned items_sent;
  bit          idle_en;
  int unsigned receiver_hold;

  // Generate clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Magnitude of a signed operand, kept unsigned so the most negative fits
  function automatic logic [DW-1:0] operand_magnitude(input logic [DW-1:0] v);
    if (v[DW-1]) return ~v + 1'b1;
    return v;
  endfunction

  function automatic logic [DW-1:0] euclid_gcd(input logic [DW-1:0] a,
                                               input logic [DW-1:0] b);
    logic [DW-1:0] r;
    while (b != '0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // Fold one accepted operand into the predicted divisor
  task automatic fold_operand(input logic [DW-1:0] v, input logic l);
    logic [DW-1:0] mag;
    mag = operand_magnitude(v);
    if (set_open) begin
      running_gcd = mag;
      set_open    = 1'b0;
    end else if (running_gcd != 1) begin
      running_gcd = euclid_gcd(mag, running_gcd);
    end
    if (l) begin
      divisor_q.push_back(running_gcd);
      running_gcd = '0;
      set_open    = 1'b1;
    end
  endtask

  // Send one operand beat; call and return at a falling edge
  task automatic send_operand(input logic [DW-1:0] v, input logic l);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      operand_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    operand_ch.valid = 1'b1;
    operand_ch.value = v;
    operand_ch.last  = l;
    do @(posedge clk); while (!operand_ch.ready);
    fold_operand(v, l);
    items_sent++;
    @(negedge clk);
  endtask

  // Send a whole set, flag the final operand
  task automatic send_set(input logic [DW-1:0] ops[$]);
    foreach (ops[i]) send_operand(ops[i], i == ops.size() - 1);
  endtask

  // Draw an operand: extremes, raw bits, multiples of a set factor, etc.
  function automatic logic [DW-1:0] draw_operand(input logic [DW-1:0] factor);
    logic [DW-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: v = '0;
          1: v = 1;
          2: v = '1;
          3: v = {1'b0, {(DW-1){1'b1}}};
          4: v = {1'b1, {(DW-1){1'b0}}};
          default: v = {1'b1, {(DW-2){1'b0}}, 1'b1};
        endcase
      end
      1, 2: v = $urandom;
      7: v = $urandom_range(0, 40) - 20;
      8, 9: begin
        v = 1 << $urandom_range(0, DW - 1);
        if ($urandom_range(0, 1)) v = ~v + 1'b1;
      end
      default: begin
        v = factor * $urandom_range(0, 32'h7fff_ffff / factor);
        if ($urandom_range(0, 1)) v = ~v + 1'b1;
      end
    endcase
    return v;
  endfunction

  task automatic send_random_set();
    logic [DW-1:0] ops[$];
    logic [DW-1:0] factor;
    int unsigned   len;
    factor = $urandom_range(1, 4095) << $urandom_range(0, 12);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
    repeat (len) ops.push_back(draw_operand(factor));
    send_set(ops);
  endtask

  // Edge values, single operands, zero sets and early collapse to one
  task automatic test_directed();
    idle_en = 1'b1;
    send_set('{0});
    send_set('{1});
    send_set('{-1});
    send_set('{32'h7fff_ffff});
    send_set('{32'h8000_0000});
    send_set('{-6});
    send_set('{0, 0, 0});
    send_set('{12, -18, 30});
    send_set('{0, 15});
    send_set('{15, 0});
    send_set('{7, 5, 100, 32'h8000_0000});
    send_set('{32'h8000_0000, 32'h8000_0000});
    send_set('{32'h8000_0000, 32'h4000_0000});
    send_set('{32'h7fff_ffff, 32'h7fff_fffe});
  endtask

  // Random sets with idling on both sides
  task automatic test_random(input int unsigned count);
    int unsigned target;
    idle_en = 1'b1;
    target = items_sent + count;
    while (items_sent < target) send_random_set();
  endtask

  // Random sets back to back, no idling anywhere
  task automatic test_back_to_back(input int unsigned count);
    int unsigned target;
    idle_en = 1'b0;
    target = items_sent + count;
    while (items_sent < target) send_random_set();
    idle_en = 1'b1;
  endtask

  // Hold the receiver off while single-operand sets keep coming
  task automatic test_backpressure();
    logic [DW-1:0] ops[$];
    idle_en       = 1'b0;
    receiver_hold = 300;
    repeat (20) begin
      ops.delete();
      ops.push_back($urandom);
      send_set(ops);
    end
    idle_en = 1'b1;
  endtask

  // Receiver: draw a stall per beat and check each divisor
  initial begin : receiver
    int unsigned   stall;
    logic [DW-1:0] want;
    gcd_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = idle_en ? $urandom_range(0, 4) : 0;
      stall += receiver_hold;
      receiver_hold = 0;
      if (stall > 0) begin
        gcd_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      gcd_ch.ready = 1'b1;
      do @(posedge clk); while (!gcd_ch.valid);
      if (divisor_q.size() == 0) begin
        $error("divisor: unexpected beat, actual %0h", gcd_ch.divisor);
        errors++;
      end else begin
        want = divisor_q.pop_front();
        if (gcd_ch.divisor !== want) begin
          $error("divisor: expected %0h, actual %0h", want, gcd_ch.divisor);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((operand_ch.valid && operand_ch.ready) || (gcd_ch.valid && gcd_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("multi_operand_gcd regression: fail");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    errors           = 0;
    items_sent       = 0;
    idle_en          = 1'b1;
    receiver_hold    = 0;
    running_gcd      = '0;
    set_open         = 1'b1;
    operand_ch.valid = 1'b0;
    operand_ch.value = '0;
    operand_ch.last  = 1'b0;
    rst_n            = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_random(RANDOM_ITEMS / 2);
    test_backpressure();
    test_back_to_back(150);
    test_random(RANDOM_ITEMS / 2 - 150);

    // Drop valid and drain
    operand_ch.valid = 1'b0;
    while (divisor_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("multi_operand_gcd regression: pass");
    end else begin
      $display("multi_operand_gcd regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
